FILE: src/dvp_pkg.sv
// ----------------------------------------------------------------------------
// dvp_pkg
// Shared types and constants of the delta varint pointer decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dvp_pkg;

  localparam int WINDOW_MAX_DEF = 4096;

  localparam int VAL_W  = 64;
  localparam int IDX_W  = 12;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 2;
  localparam int BC_W   = 4;
  localparam int SH_W   = 7;
  localparam int LO_W   = 48;   // 32 x 16 partial product
  localparam int HI_W   = 32;   // upper partial product, kept mod 2^32

  // header lengths in bytes
  localparam logic [BC_W-1:0] SIZE_BYTES = 4'd4;
  localparam logic [BC_W-1:0] POS_BYTES  = 4'd8;

  // LEB128 constants
  localparam logic [6:0]      LEB_MASK      = 7'd127;
  localparam logic [SH_W-1:0] LEB_STEP      = 7'd7;
  localparam logic [SH_W-1:0] LEB_SHIFT_END = 7'd64;
  localparam logic [BC_W-1:0] LEB_MAX_BYTES = 4'd10;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_STRIDE = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_STEP   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_BASE   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_SIZE = 2'd0;
  localparam logic [1:0] KIND_POS  = 2'd1;
  localparam logic [1:0] KIND_LEN  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BIG  = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_FIRST,
    PH_DELTA,
    PH_LEN,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    OP_SIZE,    // window size, accepted
    OP_BIG,     // window size, too large
    OP_FIRST,   // first position
    OP_DELTA,   // position from a varint delta
    OP_LERR,    // varint too long
    OP_LEN      // length byte
  } op_t;

  // parser -> scaler request
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic [VAL_W-1:0] value;
  } req_t;

  // scaler -> accumulator request
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic [VAL_W-1:0] value;
    logic [LO_W-1:0]  prod_lo;
    logic [HI_W-1:0]  prod_hi;
  } scl_t;

endpackage

`default_nettype wire

FILE: src/delta_varint_pointer_decoder.sv
// ----------------------------------------------------------------------------
// delta_varint_pointer_decoder
// Decodes a compressed pointer record, one byte per request, into window
// size, position and length results.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_byte carry the record stream, one byte per request.
//   A record is a 4-byte size W, an 8-byte first position, W-1 LEB128 deltas
//   and W length bytes. out_valid/out_ready carry results: kind, item_index,
//   out_value, status, record_last (set on the final result of a record).
//   cfg_valid/cfg_ready/cfg_index/cfg_data write position_stride (0),
//   length_step (1) and length_base (2); cfg_ready is always high and other
//   indexes are ignored. Write them only while the block is idle.
//   Throughput is one byte per cycle while out_ready is high. Each result
//   passes the parser register, the multiplier register, and the result
//   register, where the position add closes on the previous position.
//   When out_ready is low the stages fill and in_ready drops; nothing is lost.
//   Reset returns the parser to the header, empties the pipeline and loads
//   the register defaults (stride 1, step 1, base 0).
//   An oversized window or a varint over ten bytes gives an error result with
//   record_last set, and parsing restarts at the next header.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_varint_pointer_decoder import dvp_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             kind,
  output logic [IDX_W-1:0]       item_index,
  output logic [VAL_W-1:0]       out_value,
  output logic [1:0]             status,
  output logic                   record_last,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  logic [CFG_W-1:0] position_stride;
  logic [CFG_W-1:0] length_step;
  logic [CFG_W-1:0] length_base;

  logic req_valid, req_ready, scl_valid, scl_ready;
  req_t req;
  scl_t scl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_stride <= CFG_W'(1);
      length_step     <= CFG_W'(1);
      length_base     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STRIDE: position_stride <= cfg_data;
        CFG_STEP:   length_step     <= cfg_data;
        CFG_BASE:   length_base     <= cfg_data;
        default: ;
      endcase
    end
  end

  dvp_parser #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready)
  );

  dvp_scale u_scale (
    .clk             (clk),
    .rst             (rst),
    .position_stride (position_stride),
    .length_step     (length_step),
    .req_valid       (req_valid),
    .req             (req),
    .req_ready       (req_ready),
    .scl_valid       (scl_valid),
    .scl             (scl),
    .scl_ready       (scl_ready)
  );

  dvp_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .length_base (length_base),
    .scl_valid   (scl_valid),
    .scl         (scl),
    .scl_ready   (scl_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .item_index  (item_index),
    .out_value   (out_value),
    .status      (status),
    .record_last (record_last)
  );

  // error results always close the record
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> record_last)
    else $error("error result without record_last");

  // size results carry index zero
  a_size_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_SIZE) |-> (item_index == '0))
    else $error("size result with nonzero index");

  // overlong varint reports a zero position
  a_long_val: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_LONG) |-> (kind == KIND_POS) && (out_value == '0))
    else $error("malformed varint error result");

endmodule

`default_nettype wire

FILE: src/dvp_parser.sv
// ----------------------------------------------------------------------------
// dvp_parser
// Byte parser: header, LEB128 deltas and length bytes; one request per result.
// ----------------------------------------------------------------------------
`default_nettype none

module dvp_parser import dvp_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            req_valid,
  output req_t            req,
  input  wire logic       req_ready
);

  localparam int WCW = $clog2(WINDOW_MAX + 1);

  phase_t            phase, phase_next;
  logic [BC_W-1:0]   byte_count, byte_count_next;
  logic [WCW-1:0]    window_count, window_count_next;
  logic [WCW-1:0]    element_index, element_index_next;
  logic [VAL_W-1:0]  accumulator, accumulator_next;
  logic [SH_W-1:0]   shift_offset, shift_offset_next;
  logic              req_emit;
  req_t              req_next;

  logic              accept;
  logic [VAL_W-1:0]  acc_hdr, acc_leb;
  logic [BC_W-1:0]   bc_inc;
  logic [31:0]       wsize;
  logic              too_big, size_done, pos_done, cont, leb_err, idx_end, wc_many;
  logic [WCW-1:0]    ei_inc;

  assign in_ready = !req_valid || req_ready;
  assign accept   = in_valid && in_ready;

  assign acc_hdr   = accumulator | ({56'd0, in_byte} << {byte_count[2:0], 3'b000});
  assign acc_leb   = (shift_offset < LEB_SHIFT_END)
                   ? (accumulator | ({57'd0, in_byte[6:0] & LEB_MASK} << shift_offset[5:0]))
                   : accumulator;
  assign bc_inc    = byte_count + 4'd1;
  assign wsize     = acc_hdr[31:0];
  assign too_big   = wsize > 32'(WINDOW_MAX);
  assign size_done = bc_inc == SIZE_BYTES;
  assign pos_done  = bc_inc == POS_BYTES;
  assign cont      = in_byte[7];
  assign leb_err   = cont && (bc_inc >= LEB_MAX_BYTES);
  assign ei_inc    = element_index + WCW'(1);
  assign idx_end   = ei_inc >= window_count;
  assign wc_many   = window_count > WCW'(1);

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      case (phase)
        PH_SIZE: begin
          if (size_done) begin
            if (too_big)         phase_next = PH_SIZE;
            else if (wsize == 0) phase_next = PH_SKIP;
            else                 phase_next = PH_FIRST;
          end
        end
        PH_FIRST: begin
          if (pos_done) phase_next = wc_many ? PH_DELTA : PH_LEN;
        end
        PH_SKIP: begin
          if (pos_done) phase_next = PH_SIZE;
        end
        PH_DELTA: begin
          if (leb_err)               phase_next = PH_SIZE;
          else if (!cont && idx_end) phase_next = PH_LEN;
        end
        PH_LEN: begin
          if (idx_end) phase_next = PH_SIZE;
        end
        default: phase_next = PH_SIZE;
      endcase
    end
  end

  // datapath and request
  always_comb begin
    byte_count_next    = byte_count;
    window_count_next  = window_count;
    element_index_next = element_index;
    accumulator_next   = accumulator;
    shift_offset_next  = shift_offset;
    req_emit           = 1'b0;
    req_next.op        = OP_SIZE;
    req_next.idx       = IDX_W'(element_index);
    req_next.last      = 1'b0;
    req_next.value     = acc_hdr;
    if (accept) begin
      case (phase)
        PH_SIZE: begin
          accumulator_next = acc_hdr;
          byte_count_next  = bc_inc;
          if (size_done) begin
            accumulator_next = '0;
            byte_count_next  = '0;
            shift_offset_next = '0;
            req_emit         = 1'b1;
            req_next.idx     = '0;
            req_next.value   = {32'd0, wsize};
            if (too_big) begin
              req_next.op   = OP_BIG;
              req_next.last = 1'b1;
            end else begin
              req_next.op        = OP_SIZE;
              req_next.last      = wsize == 0;
              window_count_next  = wsize[WCW-1:0];
              element_index_next = '0;
            end
          end
        end
        PH_FIRST, PH_SKIP: begin
          accumulator_next = acc_hdr;
          byte_count_next  = bc_inc;
          if (pos_done) begin
            accumulator_next  = '0;
            byte_count_next   = '0;
            shift_offset_next = '0;
            if (phase == PH_FIRST) begin
              req_emit           = 1'b1;
              req_next.op        = OP_FIRST;
              req_next.idx       = '0;
              element_index_next = wc_many ? WCW'(1) : '0;
            end
          end
        end
        PH_DELTA: begin
          accumulator_next = acc_leb;
          byte_count_next  = bc_inc;
          req_next.value   = acc_leb;
          if (cont) begin
            if (leb_err) begin
              accumulator_next  = '0;
              byte_count_next   = '0;
              shift_offset_next = '0;
              req_emit          = 1'b1;
              req_next.op       = OP_LERR;
              req_next.last     = 1'b1;
            end else begin
              shift_offset_next = shift_offset + LEB_STEP;
            end
          end else begin
            accumulator_next   = '0;
            byte_count_next    = '0;
            shift_offset_next  = '0;
            req_emit           = 1'b1;
            req_next.op        = OP_DELTA;
            element_index_next = idx_end ? '0 : ei_inc;
          end
        end
        PH_LEN: begin
          accumulator_next   = '0;
          byte_count_next    = '0;
          shift_offset_next  = '0;
          req_emit           = 1'b1;
          req_next.op        = OP_LEN;
          req_next.last      = idx_end;
          req_next.value     = {56'd0, in_byte};
          element_index_next = idx_end ? '0 : ei_inc;
        end
        default: begin
          accumulator_next  = '0;
          byte_count_next   = '0;
          shift_offset_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIZE;
      byte_count    <= '0;
      window_count  <= '0;
      element_index <= '0;
      accumulator   <= '0;
      shift_offset  <= '0;
      req_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      window_count  <= window_count_next;
      element_index <= element_index_next;
      accumulator   <= accumulator_next;
      shift_offset  <= shift_offset_next;
      if (in_ready) req_valid <= req_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && req_emit) req <= req_next;
  end

endmodule

`default_nettype wire

FILE: src/dvp_scale.sv
// ----------------------------------------------------------------------------
// dvp_scale
// Multiply stage: delta by stride in two 32 x 16 halves, or length byte by step.
// ----------------------------------------------------------------------------
`default_nettype none

module dvp_scale import dvp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CFG_W-1:0] position_stride,
  input  wire logic [CFG_W-1:0] length_step,
  input  wire logic             req_valid,
  input  wire req_t             req,
  output logic                  req_ready,
  output logic                  scl_valid,
  output scl_t                  scl,
  input  wire logic             scl_ready
);

  logic [31:0]      mul_a;
  logic [CFG_W-1:0] mul_b;
  logic [LO_W-1:0]  lo_prod, hi_prod;
  scl_t             scl_next;

  assign req_ready = !scl_valid || scl_ready;

  // share the low multiplier between deltas and length bytes
  assign mul_a   = (req.op == OP_LEN) ? {24'd0, req.value[7:0]} : req.value[31:0];
  assign mul_b   = (req.op == OP_LEN) ? length_step : position_stride;
  assign lo_prod = mul_a * mul_b;
  assign hi_prod = req.value[63:32] * position_stride;

  always_comb begin
    scl_next.op      = req.op;
    scl_next.idx     = req.idx;
    scl_next.last    = req.last;
    scl_next.value   = req.value;
    scl_next.prod_lo = lo_prod;
    scl_next.prod_hi = hi_prod[HI_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl_valid <= 1'b0;
    end else if (req_ready) begin
      scl_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) scl <= scl_next;
  end

endmodule

`default_nettype wire

FILE: src/dvp_accum.sv
// ----------------------------------------------------------------------------
// dvp_accum
// Final stage: sums partial products with the previous position, adds the
// length base, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dvp_accum import dvp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CFG_W-1:0] length_base,
  input  wire logic             scl_valid,
  input  wire scl_t             scl,
  output logic                  scl_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            kind,
  output logic [IDX_W-1:0]      item_index,
  output logic [VAL_W-1:0]      out_value,
  output logic [1:0]            status,
  output logic                  record_last
);

  logic [VAL_W-1:0] prev_position;
  logic [VAL_W-1:0] value_next;
  logic [1:0]       kind_next, status_next;
  logic             load_prev;

  assign scl_ready = !out_valid || out_ready;

  always_comb begin
    value_next  = scl.value;
    kind_next   = KIND_POS;
    status_next = ST_OK;
    load_prev   = 1'b0;
    case (scl.op)
      OP_SIZE: kind_next = KIND_SIZE;
      OP_BIG: begin
        kind_next   = KIND_SIZE;
        status_next = ST_BIG;
      end
      OP_FIRST: load_prev = 1'b1;
      OP_DELTA: begin
        value_next = {scl.prod_hi, 32'd0} + {16'd0, scl.prod_lo} + prev_position;
        load_prev  = 1'b1;
      end
      OP_LERR: begin
        value_next  = '0;
        status_next = ST_LONG;
      end
      OP_LEN: begin
        kind_next  = KIND_LEN;
        value_next = {16'd0, scl.prod_lo} + {48'd0, length_base};
      end
      default: value_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      prev_position <= '0;
    end else if (scl_ready) begin
      out_valid <= scl_valid;
      if (scl_valid && load_prev) prev_position <= value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (scl_ready && scl_valid) begin
      kind        <= kind_next;
      item_index  <= scl.idx;
      out_value   <= value_next;
      status      <= status_next;
      record_last <= scl.last;
    end
  end

endmodule

`default_nettype wire
